// ===== hdl/wdr_pkg.sv =====
// Shared types and constants for the weighted distance ranker.
`timescale 1ns / 1ps
package wdr_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int MAX_FEATURES = 8;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int FEAT_W       = 16;
    localparam int WGT_W        = 16;
    localparam int NF_W         = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int ROW_W        = MAX_FEATURES * FEAT_W;
    localparam int DIST_W       = 27;
    localparam int MAG_W        = 16;
    localparam int PROD_W       = WGT_W + MAG_W;
    localparam int Q_W          = PROD_W - 8;
    localparam int SQR_W        = 2 * Q_W;
    localparam int SUM_W        = SQR_W + 3;
    localparam int RAD_W        = SUM_W + 1;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int REM_W        = ROOT_W + 3;
    localparam int SQRT_STAGES  = RAD_W / 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_FEATURES = 2'd0,
        CFG_WEIGHTS_LOW  = 2'd1,
        CFG_WEIGHTS_HIGH = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        KIND_RANK   = 1'b0,
        KIND_REJECT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SORT,
        ST_EMIT,
        ST_REJECT
    } state_t;

    typedef struct packed {
        logic               command;
        logic signed [15:0] feature_0;
        logic signed [15:0] feature_1;
        logic signed [15:0] feature_2;
        logic signed [15:0] feature_3;
        logic signed [15:0] feature_4;
        logic signed [15:0] feature_5;
        logic signed [15:0] feature_6;
        logic signed [15:0] feature_7;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  entry_index;
        logic [26:0] distance;
        logic        last;
    } out_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] sum;
    } sum_item_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] metric;
        logic [IDX_W-1:0]  idx;
    } sort_item_t;

    typedef struct packed {
        logic clear;
        logic ins;
        logic shift;
    } sort_ctl_t;

endpackage

// ===== hdl/weighted_distance_ranker.sv =====
// Top level: feature library, distance pipeline, square root chain, sorter chain.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  command  | cmd_valid cmd_stall cmd_data     | in
//  result   | res_valid res_stall res_data     | out
//  config   | cfg_write cfg_index cfg_data     | in
//
// Add: stored when accepted; a rejected add gives one reject result.
// Query over n entries: ranked first, then n results go out one per cycle
// when the result side does not stall; ranking passes the one-row-per-cycle
// library read and the 5-stage distance plus 26-stage square root pipeline.
// One request at a time; cmd_stall stays high until the last result is loaded.
// Reset empties the library; stored rows are not cleared.
`timescale 1ns / 1ps
module weighted_distance_ranker
    import wdr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  in_t                   cmd_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output out_t                  res_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, n_reg, scan_cnt_reg, ins_cnt_reg, emit_cnt_reg;
    logic [NF_W-1:0]       nf_reg;
    logic [CFG_DATA_W-1:0] wlo_reg, whi_reg;
    logic [ROW_W-1:0]      query_reg;
    logic [ROW_W-1:0]      mem [MAX_ENTRIES];
    logic [ROW_W-1:0]      rd_row_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_valid_reg;
    out_t                  out_reg;
    logic                  out_valid_reg;

    logic                  accept, full, out_free, issue, emit_ld, rej_ld, emit_last;
    logic [ROW_W-1:0]      feat_vec;
    sum_item_t             sum_s;
    root_t                 sq_s [SQRT_STAGES+1];
    sort_item_t            new_item;
    sort_item_t            cells [MAX_ENTRIES];
    logic                  lts [MAX_ENTRIES];
    sort_ctl_t             sctl;

    assign feat_vec = {cmd_data.feature_7, cmd_data.feature_6, cmd_data.feature_5,
                       cmd_data.feature_4, cmd_data.feature_3, cmd_data.feature_2,
                       cmd_data.feature_1, cmd_data.feature_0};
    assign full      = (count_reg == CNT_W'(MAX_ENTRIES));
    assign out_free  = !out_valid_reg || !res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign emit_last = (emit_cnt_reg == n_reg - 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_data.command == CMD_ADD)
                    begin
                        state_next = full ? ST_REJECT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_IDLE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == n_reg - 1'b1)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (ins_cnt_reg == n_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REJECT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_stall  = 1'b1;
        issue      = 1'b0;
        emit_ld    = 1'b0;
        rej_ld     = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd_stall = 1'b0;
            ST_SCAN:   issue     = 1'b1;
            ST_SORT:   issue     = 1'b0;
            ST_EMIT:   emit_ld   = out_free;
            ST_REJECT: rej_ld    = out_free;
            default:   cmd_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            scan_cnt_reg  <= '0;
            ins_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            nf_reg        <= NF_W'(MAX_FEATURES);
            wlo_reg       <= 64'h0100_0100_0100_0100;
            whi_reg       <= 64'h0100_0100_0100_0100;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_NUM_FEATURES: nf_reg  <= cfg_data[NF_W-1:0];
                    CFG_WEIGHTS_LOW:  wlo_reg <= cfg_data;
                    CFG_WEIGHTS_HIGH: whi_reg <= cfg_data;
                    default:          nf_reg  <= nf_reg;
                endcase
            end
            if (accept && cmd_data.command == CMD_ADD && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (accept && cmd_data.command == CMD_QUERY)
            begin
                n_reg        <= count_reg;
                scan_cnt_reg <= '0;
                ins_cnt_reg  <= '0;
                emit_cnt_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (sctl.ins)
                begin
                    ins_cnt_reg <= ins_cnt_reg + 1'b1;
                end
                if (emit_ld)
                begin
                    emit_cnt_reg <= emit_cnt_reg + 1'b1;
                end
            end
            if (emit_ld || rej_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // library memory and query latch
    always_ff @(posedge clk)
    begin
        if (accept && cmd_data.command == CMD_ADD && !full)
        begin
            mem[count_reg[IDX_W-1:0]] <= feat_vec;
        end
        if (accept)
        begin
            query_reg <= feat_vec;
        end
        rd_row_reg <= mem[scan_cnt_reg[IDX_W-1:0]];
        rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (rej_ld)
        begin
            out_reg.kind        <= KIND_REJECT;
            out_reg.entry_index <= '0;
            out_reg.distance    <= '0;
            out_reg.last        <= 1'b1;
        end
        else if (emit_ld)
        begin
            out_reg.kind        <= KIND_RANK;
            out_reg.entry_index <= cells[0].idx;
            out_reg.distance    <= cells[0].metric;
            out_reg.last        <= emit_last;
        end
    end

    wdr_dist u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (rd_valid_reg),
        .row_idx      (rd_idx_reg),
        .row_data     (rd_row_reg),
        .query        (query_reg),
        .weights      ({whi_reg, wlo_reg}),
        .num_features (nf_reg),
        .sum_out      (sum_s)
    );

    assign sq_s[0].valid = sum_s.valid;
    assign sq_s[0].idx   = sum_s.idx;
    assign sq_s[0].rad   = {1'b0, sum_s.sum};
    assign sq_s[0].rem   = '0;
    assign sq_s[0].root  = '0;

    genvar s;
    generate
        for (s = 0; s < SQRT_STAGES; s++)
        begin : g_sqrt
            wdr_sqrt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .in_s  (sq_s[s]),
                .out_s (sq_s[s+1])
            );
        end
    endgenerate

    assign new_item.valid  = sq_s[SQRT_STAGES].valid;
    assign new_item.metric = DIST_W'(sq_s[SQRT_STAGES].root);
    assign new_item.idx    = sq_s[SQRT_STAGES].idx;

    assign sctl.clear = accept && (cmd_data.command == CMD_QUERY);
    assign sctl.ins   = new_item.valid;
    assign sctl.shift = emit_ld;

    genvar c;
    generate
        for (c = 0; c < MAX_ENTRIES; c++)
        begin : g_sort
            sort_item_t prev_i;
            sort_item_t next_i;
            logic       prev_l;
            if (c == 0)
            begin : g_head
                assign prev_i = new_item;
                assign prev_l = 1'b0;
            end
            else
            begin : g_body
                assign prev_i = cells[c-1];
                assign prev_l = lts[c-1];
            end
            if (c == MAX_ENTRIES - 1)
            begin : g_tail
                assign next_i = '0;
            end
            else
            begin : g_mid
                assign next_i = cells[c+1];
            end
            wdr_sort_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (sctl),
                .new_item  (new_item),
                .prev_item (prev_i),
                .prev_lt   (prev_l),
                .next_item (next_i),
                .held      (cells[c]),
                .lt        (lts[c])
            );
        end
    endgenerate

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("library count out of range");
    a_ins_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ins_cnt_reg <= n_reg)
        else $error("more ranked entries than library entries");
    a_emit_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cells[0].valid)
        else $error("emitting from an empty sorter");
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.kind == KIND_REJECT |-> res_data.last)
        else $error("reject result not marked last");
`endif

endmodule

// ===== hdl/wdr_dist.sv =====
// Weighted squared-distance pipeline: lane products, squares and adder tree.
`timescale 1ns / 1ps
module wdr_dist
    import wdr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          row_valid,
    input  logic [IDX_W-1:0]              row_idx,
    input  logic [ROW_W-1:0]              row_data,
    input  logic [ROW_W-1:0]              query,
    input  logic [MAX_FEATURES*WGT_W-1:0] weights,
    input  logic [NF_W-1:0]               num_features,
    output sum_item_t                     sum_out
);

    logic [Q_W-1:0]     q_reg   [MAX_FEATURES];
    logic [Q_W-1:0]     q_next  [MAX_FEATURES];
    logic [SQR_W-1:0]   sq_reg  [MAX_FEATURES];
    logic [SQR_W:0]     s3_reg  [MAX_FEATURES/2];
    logic [SQR_W+1:0]   s4_reg  [MAX_FEATURES/4];
    logic [SUM_W-1:0]   s5_reg;
    logic [4:0]         vld_reg;
    logic [IDX_W-1:0]   idx_reg [5];

    genvar l;
    generate
        for (l = 0; l < MAX_FEATURES; l++)
        begin : g_lane
            logic [FEAT_W:0]   diff;
            logic [FEAT_W:0]   mag;
            logic [PROD_W-1:0] prod;
            always_comb
            begin
                diff = {query[l*FEAT_W+FEAT_W-1], query[l*FEAT_W +: FEAT_W]}
                     - {row_data[l*FEAT_W+FEAT_W-1], row_data[l*FEAT_W +: FEAT_W]};
                mag  = diff[FEAT_W] ? (~diff + 1'b1) : diff;
                prod = weights[l*WGT_W +: WGT_W] * mag[MAG_W-1:0];
                q_next[l] = (NF_W'(l) < num_features) ? prod[PROD_W-1:8] : '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_FEATURES; i++)
        begin
            q_reg[i]  <= q_next[i];
            sq_reg[i] <= q_reg[i] * q_reg[i];
        end
        for (int i = 0; i < MAX_FEATURES/2; i++)
        begin
            s3_reg[i] <= {1'b0, sq_reg[2*i]} + {1'b0, sq_reg[2*i+1]};
        end
        for (int i = 0; i < MAX_FEATURES/4; i++)
        begin
            s4_reg[i] <= {1'b0, s3_reg[2*i]} + {1'b0, s3_reg[2*i+1]};
        end
        s5_reg <= {1'b0, s4_reg[0]} + {1'b0, s4_reg[1]};
        idx_reg[0] <= row_idx;
        for (int i = 1; i < 5; i++)
        begin
            idx_reg[i] <= idx_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], row_valid};
        end
    end

    assign sum_out.valid = vld_reg[4];
    assign sum_out.idx   = idx_reg[4];
    assign sum_out.sum   = s5_reg;

endmodule

// ===== hdl/wdr_sqrt_cell.sv =====
// One stage of the pipelined integer square root: two radicand bits per stage.
`timescale 1ns / 1ps
module wdr_sqrt_cell
    import wdr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  root_t in_s,
    output root_t out_s
);

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    root_t            nxt;

    always_comb
    begin
        rem_sh    = {in_s.rem[REM_W-3:0], in_s.rad[RAD_W-1 -: 2]};
        trial     = {1'b0, in_s.root, 2'b01};
        nxt.valid = in_s.valid;
        nxt.idx   = in_s.idx;
        nxt.rad   = {in_s.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            nxt.rem  = rem_sh - trial;
            nxt.root = {in_s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = rem_sh;
            nxt.root = {in_s.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_s <= '0;
        end
        else
        begin
            out_s <= nxt;
        end
    end

endmodule

// ===== hdl/wdr_sort_cell.sv =====
// Insertion sorter cell: keeps one ranked entry, shifts toward the head on emit.
`timescale 1ns / 1ps
module wdr_sort_cell
    import wdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sort_ctl_t  ctl,
    input  sort_item_t new_item,
    input  sort_item_t prev_item,
    input  logic       prev_lt,
    input  sort_item_t next_item,
    output sort_item_t held,
    output logic       lt
);

    sort_item_t held_reg;
    sort_item_t held_next;

    // empty cells sort after everything; ties keep the older (lower index) entry
    assign lt = !held_reg.valid || (new_item.metric < held_reg.metric);

    always_comb
    begin
        held_next = held_reg;
        priority if (ctl.clear)
        begin
            held_next = '0;
        end
        else if (ctl.shift)
        begin
            held_next = next_item;
        end
        else if (ctl.ins && lt)
        begin
            held_next = prev_lt ? prev_item : new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

// ===== dv/tb_weighted_distance_ranker.sv =====
// Self-checking testbench for the weighted distance ranker.
`timescale 1ns / 1ps
module tb_weighted_distance_ranker
    import wdr_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped register index
    localparam logic [63:0] W_UNITY = 64'h0100_0100_0100_0100;
    localparam logic [63:0] W_FULL  = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    in_t                   cmd_data = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    out_t                  res_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    weighted_distance_ranker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [3:0]   pred_nf = 4'd8;
    logic [63:0]  pred_wlo = W_UNITY;
    logic [63:0]  pred_whi = W_UNITY;
    logic [127:0] lib_rows [MAX_ENTRIES];
    int           lib_count = 0;

    in_t  pending_req [$];
    out_t expected_results [$];
    int   errors = 0;
    int   mismatches = 0;
    int   adds_issued = 0;
    bit   no_idle = 1'b0;

    logic cmd_took = 1'b0;
    logic res_took = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    bit   hold_go = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    task automatic enqueue_req(in_t req);
        pending_req = {pending_req, req};
    endtask

    task automatic add_expected(out_t r);
        expected_results = {expected_results, r};
    endtask

    function automatic logic [15:0] lane_of(logic [127:0] row, int i);
        return row[127 - 16*i -: 16];
    endfunction

    function automatic logic [26:0] floor_root(longint unsigned s);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 26; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= s)
                r = t;
        end
        return r[26:0];
    endfunction

    function automatic logic [26:0] weighted_dist(logic [127:0] qv, logic [127:0] row);
        int lanes;
        longint d;
        longint unsigned w;
        longint unsigned q;
        longint unsigned s;
        lanes = (pred_nf > 8) ? 8 : pred_nf;
        s = 0;
        for (int i = 0; i < lanes; i++)
        begin
            d = longint'($signed(lane_of(qv, i))) - longint'($signed(lane_of(row, i)));
            if (d < 0)
                d = -d;
            w = (i < 4) ? pred_wlo[16*i +: 16] : pred_whi[16*(i-4) +: 16];
            q = (w * longint'(d)) >> 8;
            s += q * q;
        end
        return floor_root(s);
    endfunction

    task automatic predict_request(in_t req);
        logic [26:0] rank_dist [MAX_ENTRIES];
        int order [MAX_ENTRIES];
        logic [26:0] dv;
        int j;
        out_t r;
        if (req.command == CMD_ADD)
        begin
            if (lib_count >= MAX_ENTRIES)
            begin
                r.kind = KIND_REJECT;
                r.entry_index = '0;
                r.distance = '0;
                r.last = 1'b1;
                add_expected(r);
            end
            else
            begin
                lib_rows[lib_count] = req[127:0];
                lib_count++;
            end
        end
        else
        begin
            // stable insertion: equal distances keep the lower index first
            for (int i = 0; i < lib_count; i++)
            begin
                dv = weighted_dist(req[127:0], lib_rows[i]);
                j = i;
                while (j > 0 && rank_dist[j-1] > dv)
                begin
                    rank_dist[j] = rank_dist[j-1];
                    order[j] = order[j-1];
                    j--;
                end
                rank_dist[j] = dv;
                order[j] = i;
            end
            for (int i = 0; i < lib_count; i++)
            begin
                r.kind = KIND_RANK;
                r.entry_index = order[i][5:0];
                r.distance = rank_dist[i];
                r.last = (i == lib_count - 1);
                add_expected(r);
            end
        end
    endtask

    function automatic in_t rand_request(bit is_query);
        in_t req;
        logic [15:0] v;
        req = '0;
        req.command = is_query ? CMD_QUERY : CMD_ADD;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 9))
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                2: v = 16'h0000;
                3, 4, 5: v = 16'($urandom_range(0, 4) * 256 - 512);  // clustered, forces ties
                default: v = 16'($urandom);
            endcase
            req[127 - 16*i -: 16] = v;
        end
        return req;
    endfunction

    function automatic in_t flat_request(bit is_query, logic [15:0] v);
        in_t req;
        req = '0;
        req.command = is_query ? CMD_QUERY : CMD_ADD;
        for (int i = 0; i < 8; i++)
            req[127 - 16*i -: 16] = v;
        return req;
    endfunction

    // sender: new request only after the current one was taken
    always @(negedge clk)
    begin
        if (rst_n && !(cmd_valid && !cmd_took))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                cmd_valid <= 1'b0;
            end
            else if (pending_req.size() > 0)
            begin
                cmd_data <= pending_req.pop_front();
                cmd_valid <= 1'b1;
                send_gap <= no_idle ? 0 : $urandom_range(0, 4);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_took)
                recv_gap = no_idle ? 0 : $urandom_range(0, 4);
            res_stall <= (recv_gap > 0) || (hold_left > 0);
            if (recv_gap > 0)
                recv_gap--;
        end
    end

    // long receiver hold-off, to back the block up into its input
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        out_t want;
        cmd_took <= cmd_valid && !cmd_stall;
        res_took <= res_valid && !res_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            predict_request(cmd_data);
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result %p", res_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %p actual %p", want, res_data);
                end
            end
        end
    end

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_NUM_FEATURES: pred_nf = val[3:0];
            CFG_WEIGHTS_LOW:  pred_wlo = val;
            CFG_WEIGHTS_HIGH: pred_whi = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        while (pending_req.size() > 0 || cmd_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic queue_random(int count);
        bit q;
        for (int k = 0; k < count; k++)
        begin
            q = (adds_issued == 0) ? 1'b0 : ($urandom_range(0, 99) < 35);
            if (!q)
                adds_issued++;
            enqueue_req(rand_request(q));
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty query, extreme vectors, tied entries
        enqueue_req(flat_request(1'b1, 16'h0000));
        enqueue_req(flat_request(1'b0, 16'h7FFF));
        enqueue_req(flat_request(1'b0, 16'h8000));
        enqueue_req(flat_request(1'b0, 16'h0000));
        enqueue_req(flat_request(1'b0, 16'h0000));
        enqueue_req(flat_request(1'b0, 16'h5555));
        enqueue_req(flat_request(1'b0, 16'hAAAA));
        enqueue_req(flat_request(1'b1, 16'h8000));
        enqueue_req(flat_request(1'b1, 16'h7FFF));
        enqueue_req(flat_request(1'b1, 16'h0000));
        adds_issued = 6;
        drain();

        cfg_put(CFG_WEIGHTS_LOW, W_FULL);
        cfg_put(CFG_WEIGHTS_HIGH, W_FULL);
        enqueue_req(flat_request(1'b1, 16'h8000));
        enqueue_req(flat_request(1'b1, 16'h7FFF));
        drain();

        cfg_put(CFG_NUM_FEATURES, 64'd0);   // no lanes: pure index order
        enqueue_req(flat_request(1'b1, 16'h1234));
        drain();
        cfg_put(CFG_NUM_FEATURES, 64'd15);  // clamps to all lanes
        cfg_put(CFG_SPARE, W_FULL);         // must be ignored
        enqueue_req(flat_request(1'b1, 16'h8000));
        drain();
        cfg_put(CFG_NUM_FEATURES, 64'd1);
        cfg_put(CFG_WEIGHTS_LOW, 64'h0);
        enqueue_req(flat_request(1'b1, 16'h7FFF));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: cfg_put(CFG_NUM_FEATURES, 64'd8);
                1: cfg_put(CFG_NUM_FEATURES, 64'($urandom_range(0, 15)));
                2: cfg_put(CFG_NUM_FEATURES, 64'd1);
                default: cfg_put(CFG_NUM_FEATURES, 64'($urandom_range(1, 8)));
            endcase
            cfg_put(CFG_WEIGHTS_LOW, (ph == 3) ? W_FULL : (ph == 5) ? W_UNITY
                                               : {$urandom, $urandom});
            cfg_put(CFG_WEIGHTS_HIGH, (ph == 3) ? W_FULL : (ph == 6) ? 64'h0
                                                : {$urandom, $urandom});
            no_idle = (ph == 2);
            if (ph == 4)
                hold_go = 1'b1;
            queue_random(40);
            drain();
        end

        if (errors == 0 && expected_results.size() == 0)
            $display("tb_weighted_distance_ranker passed");
        else
            $display("tb_weighted_distance_ranker failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_weighted_distance_ranker failed");
        $finish;
    end

endmodule
